FILE: src/qph_pkg.sv
// Shared types, codes and constants of the quadratic-probe hash table.
`timescale 1ns / 1ps
`default_nettype none

package qph_pkg;

	// Field widths.
	localparam int KEY_W  = 31;
	localparam int SLOT_W = 10;
	localparam int CNT_W  = 32;
	localparam int TS_W   = 11;
	localparam int MP_W   = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 1;

	// Default table depth and register reset values.
	localparam int                DEPTH_DEFAULT = 1024;
	localparam logic [TS_W-1:0]   TS_RESET      = 11'd1024;
	localparam logic [MP_W-1:0]   MP_RESET      = 16'd10000;
	localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
	localparam logic [IDX_W-1:0] REG_MAX_PROBES = 1'b1;

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_FOUND     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Input transaction payload.
	typedef struct packed {
		logic             operation;
		logic [KEY_W-1:0] key;
	} req_t;

	// Output transaction payload.
	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  insert_collisions;
		logic [CNT_W-1:0]  search_collisions;
	} rsp_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIVIDE,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic start;
		logic home_load;
		logic rd_en;
		logic check;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic div_done;
		logic probe_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: src/qph_mod_unit.sv
// Bit-serial remainder unit: key modulo table size, one key bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module qph_mod_unit #(
	parameter int AW = 10
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [qph_pkg::KEY_W-1:0] key,
	input  wire logic [AW:0]              size,
	output logic                          done,
	output logic [AW-1:0]                 rem
);

	localparam int BW = $clog2(qph_pkg::KEY_W);

	logic [qph_pkg::KEY_W-1:0] key_q;
	logic [AW:0]               rem_q;
	logic [BW-1:0]             bit_q;
	logic                      busy_q;
	logic                      done_q;
	logic [AW:0]               shifted;
	logic [AW:0]               rem_nxt;

	// Shift the next key bit in and subtract the modulus once if it fits.
	always_comb begin
		shifted = {rem_q[AW-1:0], key_q[qph_pkg::KEY_W-1]};
		if (shifted >= size) begin
			rem_nxt = shifted - size;
		end else begin
			rem_nxt = shifted;
		end
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BW'(qph_pkg::KEY_W - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and key shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			rem_q <= '0;
		end else if (busy_q) begin
			key_q <= {key_q[qph_pkg::KEY_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[AW-1:0];

endmodule

`default_nettype wire

FILE: src/qph_datapath.sv
// Datapath: configuration, slot memory, probe sequence, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module qph_datapath #(
	parameter int TABLE_DEPTH = qph_pkg::DEPTH_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wen,
	input  wire logic [qph_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [qph_pkg::CFG_W-1:0] cfg_data,
	input  wire qph_pkg::req_t             req_data,
	input  wire logic                      rsp_stall,
	input  wire qph_pkg::cmd_t             cmd,
	output qph_pkg::stat_t                 stat,
	output logic                           rsp_valid,
	output qph_pkg::rsp_t                  rsp_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int SW = AW + 1;

	typedef struct packed {
		logic                      valid;
		logic [qph_pkg::KEY_W-1:0] key;
	} entry_t;

	// Configuration registers.
	logic [qph_pkg::TS_W-1:0] table_size_q;
	logic [qph_pkg::MP_W-1:0] max_probes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= qph_pkg::TS_RESET;
			max_probes_q <= qph_pkg::MP_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				qph_pkg::REG_TABLE_SIZE: table_size_q <= qph_pkg::TS_W'(cfg_data);
				qph_pkg::REG_MAX_PROBES: max_probes_q <= cfg_data;
			endcase
		end
	end

	// Effective modulus: zero counts as one, large values clamp to the depth.
	logic [31:0]   ts_wide;
	logic [SW-1:0] size;

	always_comb begin
		ts_wide = 32'(table_size_q);
		if (ts_wide == 32'd0) begin
			size = SW'(1);
		end else if (ts_wide > 32'(TABLE_DEPTH)) begin
			size = SW'(TABLE_DEPTH);
		end else begin
			size = SW'(ts_wide);
		end
	end

	// Current operation.
	logic                      op_q;
	logic [qph_pkg::KEY_W-1:0] key_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= req_data.operation;
			key_q <= req_data.key;
		end
	end

	// Home slot computation.
	logic          div_done;
	logic [AW-1:0] home;

	qph_mod_unit #(
		.AW(AW)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.key   (req_data.key),
		.size  (size),
		.done  (div_done),
		.rem   (home)
	);

	// Probe position, step and probe index.
	logic [AW-1:0]            pos_q;
	logic [AW-1:0]            delta_q;
	logic [qph_pkg::MP_W-1:0] probe_q;
	logic [SW-1:0]            pos_sum;
	logic [SW-1:0]            delta_sum;
	logic [SW-1:0]            delta_red;

	// Next slot is the current one plus the step, modulo the size; the step grows by two, modulo the size.
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, delta_q};
		if (pos_sum >= size) begin
			pos_sum = pos_sum - size;
		end
		delta_sum = {1'b0, delta_q} + SW'(2);
		if (delta_sum >= size) begin
			delta_red = delta_sum - size;
		end else begin
			delta_red = delta_sum;
		end
		if (delta_red >= size) begin
			delta_red = delta_red - size;
		end
	end

	// Clearing sweep counter.
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Slot memory holding a valid flag and the key of every slot.
	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;
	logic   mem_we;
	logic   [AW-1:0] mem_waddr;
	entry_t mem_wdata;

	// Decision for the slot just read.
	logic                      chk_done;
	logic                      chk_write;
	logic [1:0]                chk_status;
	logic [AW-1:0]             chk_slot;
	logic                      ins_inc;
	logic                      srch_inc;
	logic                      at_home;
	logic                      at_limit;

	always_comb begin
		at_home    = (probe_q == '0);
		at_limit   = (probe_q == max_probes_q);
		chk_done   = 1'b0;
		chk_write  = 1'b0;
		chk_status = qph_pkg::ST_NOT_FOUND;
		chk_slot   = '0;
		ins_inc    = 1'b0;
		srch_inc   = 1'b0;
		if (op_q == qph_pkg::OP_INSERT) begin
			if (!rdata_q.valid) begin
				chk_done   = 1'b1;
				chk_write  = 1'b1;
				chk_status = qph_pkg::ST_INSERTED;
				chk_slot   = pos_q;
			end else begin
				ins_inc    = at_home;
				chk_done   = at_limit;
				chk_status = qph_pkg::ST_FULL;
			end
		end else begin
			if (!rdata_q.valid) begin
				chk_done = 1'b1;
			end else if (rdata_q.key == key_q) begin
				chk_done   = 1'b1;
				chk_status = qph_pkg::ST_FOUND;
				chk_slot   = pos_q;
			end else begin
				srch_inc = at_home;
				chk_done = at_limit;
			end
		end
	end

	// Memory write port: clearing sweep or insert.
	always_comb begin
		mem_we    = cmd.clear_en || (cmd.check && chk_write);
		mem_waddr = cmd.clear_en ? clr_q : pos_q;
		if (cmd.clear_en) begin
			mem_wdata = '0;
		end else begin
			mem_wdata.valid = 1'b1;
			mem_wdata.key   = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[pos_q];
		end
	end

	// Probe sequence registers.
	always_ff @(posedge clk) begin
		if (cmd.home_load) begin
			pos_q   <= home;
			delta_q <= (size == SW'(1)) ? '0 : AW'(1);
			probe_q <= '0;
		end else if (cmd.check && !chk_done) begin
			pos_q   <= AW'(pos_sum);
			delta_q <= AW'(delta_red);
			probe_q <= probe_q + 1'b1;
		end
	end

	// Saturating collision counters.
	logic [qph_pkg::CNT_W-1:0] ins_cnt_q;
	logic [qph_pkg::CNT_W-1:0] srch_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_cnt_q  <= '0;
			srch_cnt_q <= '0;
		end else if (cmd.check) begin
			if (ins_inc && (ins_cnt_q != qph_pkg::CNT_MAX)) begin
				ins_cnt_q <= ins_cnt_q + 1'b1;
			end
			if (srch_inc && (srch_cnt_q != qph_pkg::CNT_MAX)) begin
				srch_cnt_q <= srch_cnt_q + 1'b1;
			end
		end
	end

	// Result held until the output register is free.
	logic [1:0]    res_status_q;
	logic [AW-1:0] res_slot_q;

	always_ff @(posedge clk) begin
		if (cmd.check && chk_done) begin
			res_status_q <= chk_status;
			res_slot_q   <= chk_slot;
		end
	end

	// Output register.
	logic          out_valid_q;
	qph_pkg::rsp_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.status            <= res_status_q;
			out_q.slot              <= qph_pkg::SLOT_W'(res_slot_q);
			out_q.insert_collisions <= ins_cnt_q;
			out_q.search_collisions <= srch_cnt_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// Status toward the controller.
	assign stat.clear_last = (clr_q == '1);
	assign stat.div_done   = div_done;
	assign stat.probe_done = chk_done;
	assign stat.out_free   = !out_valid_q;

endmodule

`default_nettype wire

FILE: src/qph_ctrl.sv
// Controller state machine sequencing clearing, home slot computation and probing.
`timescale 1ns / 1ps
`default_nettype none

module qph_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire qph_pkg::stat_t stat,
	output qph_pkg::cmd_t       cmd
);

	qph_pkg::state_t state_q;
	qph_pkg::state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qph_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			qph_pkg::S_CLEAR: begin
				if (stat.clear_last) state_nxt = qph_pkg::S_IDLE;
			end
			qph_pkg::S_IDLE: begin
				if (req_valid) state_nxt = qph_pkg::S_DIVIDE;
			end
			qph_pkg::S_DIVIDE: begin
				if (stat.div_done) state_nxt = qph_pkg::S_READ;
			end
			qph_pkg::S_READ: begin
				state_nxt = qph_pkg::S_CHECK;
			end
			qph_pkg::S_CHECK: begin
				state_nxt = stat.probe_done ? qph_pkg::S_FINISH : qph_pkg::S_READ;
			end
			qph_pkg::S_FINISH: begin
				if (stat.out_free) state_nxt = qph_pkg::S_IDLE;
			end
			default: state_nxt = qph_pkg::S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			qph_pkg::S_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			qph_pkg::S_IDLE: begin
				req_stall = 1'b0;
				cmd.start = req_valid;
			end
			qph_pkg::S_DIVIDE: begin
				cmd.home_load = stat.div_done;
			end
			qph_pkg::S_READ: begin
				cmd.rd_en = 1'b1;
			end
			qph_pkg::S_CHECK: begin
				cmd.check = 1'b1;
			end
			qph_pkg::S_FINISH: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/quadratic_probe_hash_table_unit.sv
// Top level of the quadratic-probe hash table: controller and datapath.
// After reset the unit sweeps its slot memory clear, stalling requests.
// An operation first computes the home slot with the bit-serial modulo unit,
// then does one memory read and one check per probe.
// A new operation is accepted while a result waits in the output register.
// Reset clears control state, the collision counters and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table_unit #(
	parameter int TABLE_DEPTH = qph_pkg::DEPTH_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wen,
	input  wire logic [qph_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [qph_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire qph_pkg::req_t             req_data,
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output qph_pkg::rsp_t                  rsp_data
);

	qph_pkg::cmd_t  cmd;
	qph_pkg::stat_t stat;

	// Sequencer.
	qph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage and arithmetic.
	qph_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req_data (req_data),
		.rsp_stall(rsp_stall),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_data (rsp_data)
	);

endmodule

`default_nettype wire
